// ===== rtl/core/i2crtc_pkg.sv =====
`default_nettype none

package i2crtc_pkg;

    // Stream widths, padded to whole bytes
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    // Number of alarm bytes and of time staging bytes
    localparam int BANK_CNT = 7;

    // Bus event codes; code 7 is unused and leaves the state alone
    typedef enum logic [2:0] {
        EV_ADDR_RD = 3'd0,
        EV_ADDR_WR = 3'd1,
        EV_RX_BYTE = 3'd2,
        EV_TX_REQ  = 3'd3,
        EV_TX_NACK = 3'd4,
        EV_STOP    = 3'd5,
        EV_BUS_ERR = 3'd6
    } mode_t;

    // Register map
    localparam logic [3:0] REG_SEC        = 4'd0;
    localparam logic [3:0] REG_MIN        = 4'd1;
    localparam logic [3:0] REG_HOUR       = 4'd2;
    localparam logic [3:0] REG_WDAY       = 4'd3;
    localparam logic [3:0] REG_DATE       = 4'd4;
    localparam logic [3:0] REG_MONTH      = 4'd5;
    localparam logic [3:0] REG_YEAR       = 4'd6;
    localparam logic [3:0] REG_ALARM_0    = 4'd7;
    localparam logic [3:0] REG_CONTROL    = 4'd14;
    localparam logic [3:0] REG_OSC_STATUS = 4'd15;

    // Status reset value: oscillator stop flag set
    localparam logic [7:0] STAT_RESET = 8'h80;

    typedef logic [BANK_CNT-1:0][7:0] bank_t;

    // Live binary time from the timekeeper
    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] date;
        logic [3:0] month;
        logic [6:0] year;
    } now_t;

    // Scalar registers seen by the read mux
    typedef struct packed {
        logic [3:0] ptr;
        logic       paused;
        logic [7:0] ctrl;
        logic [7:0] status;
    } rd_src_t;

    // Binary time for a set-time command
    typedef struct packed {
        logic [6:0] sec;
        logic [7:0] min;
        logic [5:0] hour;
        logic [2:0] wday;
        logic [4:0] date;
        logic [3:0] month;
        logic [7:0] year;
    } set_t;

    // One result
    typedef struct packed {
        logic [7:0] tx_data;
        logic       tx_valid;
        logic       set_time;
        set_t       set_val;
        logic       paused;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_rtc_register_slave.sv =====
`default_nettype none

// Channel  Dir  Width    Contents
// s_*      in   48 + 3   one bus event with the live binary time
// m_*      out  56 + 2   one result per event: transmit byte, set-time command
//
// Every event gives exactly one result. An event sits in the input register,
// is processed combinationally against the register file and lands in the
// result register, one event per cycle sustained while m_tready stays high.
// The input register takes a new request whenever it is empty or moving on,
// so a result stalled on m_tready blocks requests only once the input is full.
// Reset (rst_n low, asynchronous) empties both stages and loads the
// register file: pointer 0, status 0x80, pointer byte expected, rest cleared.
module i2c_rtc_register_slave
    import i2crtc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // data_byte[7:0], now_sec[13:8], now_min[19:14], now_hour[24:20],
    // now_wday[27:25], now_date[32:28], now_month[36:33], now_year[43:37]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode[2:0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tx_data[7:0], set_sec[14:8], set_min[22:15], set_hour[28:23],
    // set_wday[31:29], set_date[36:32], set_month[40:37], set_year[48:41],
    // oscillator_paused[49]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // tx_valid[0], set_time[1]
    output logic [OUT_USER_W-1:0] m_tuser
);

    logic       in_valid_reg;
    mode_t      in_mode_reg;
    logic [7:0] in_byte_reg;
    now_t       in_now_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;

    logic       out_ready;
    logic       fire;
    logic       s_accept;
    now_t       now_in;
    res_t       res_next;

    assign out_ready = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    // Unpack the time fields
    assign now_in.sec   = s_tdata[13:8];
    assign now_in.min   = s_tdata[19:14];
    assign now_in.hour  = s_tdata[24:20];
    assign now_in.wday  = s_tdata[27:25];
    assign now_in.date  = s_tdata[32:28];
    assign now_in.month = s_tdata[36:33];
    assign now_in.year  = s_tdata[43:37];

    // Input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    // Input stage payload
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_mode_reg <= mode_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
            in_now_reg  <= now_in;
        end
    end

    i2crtc_regfile u_regfile
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (in_mode_reg),
        .data_byte (in_byte_reg),
        .now       (in_now_reg),
        .res       (res_next)
    );

    // Result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Result stage payload
    always_ff @(posedge clk)
    begin
        if (fire)
            out_res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_res_reg.set_time, out_res_reg.tx_valid};
    assign m_tdata  = {6'd0,
                       out_res_reg.paused,
                       out_res_reg.set_val.year,
                       out_res_reg.set_val.month,
                       out_res_reg.set_val.date,
                       out_res_reg.set_val.wday,
                       out_res_reg.set_val.hour,
                       out_res_reg.set_val.min,
                       out_res_reg.set_val.sec,
                       out_res_reg.tx_data};

    // Checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input stage taken while result stalled");

    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
        else $error("transmit byte not zero without tx_valid");

    a_set_unpauses: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tdata[49] && !m_tuser[0]))
        else $error("set-time result with pause flag or transmit byte");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fire))
        else $error("result appeared without a processed event");

endmodule

`default_nettype wire

// ===== rtl/core/i2crtc_bcd_read.sv =====
`default_nettype none

module i2crtc_bcd_read
    import i2crtc_pkg::*;
(
    input  rd_src_t    src,
    input  bank_t      alarm,
    input  now_t       now,
    output logic [7:0] rd_byte
);

    // Binary to BCD for values below 100; tens by reciprocal multiply
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  units;
        begin
            prod     = {11'd0, v} * 18'd205;
            tens     = prod[14:11];
            tens_x10 = {tens, 3'b000} - {3'b000, tens} - {3'b000, tens}
                       + {1'b0, tens, 2'b00};
            units    = v - tens_x10;
            bin_to_bcd = {tens, units[3:0]};
        end
    endfunction

    logic [3:0] alarm_off;
    logic [2:0] wday_rd;

    assign alarm_off = src.ptr - REG_ALARM_0;

    // Weekday renumbered: 1 Sunday to 7 Saturday
    assign wday_rd = (now.wday == 3'd7) ? 3'd1 : now.wday + 3'd1;

    // Register read mux
    always_comb
    begin
        unique case (src.ptr)
            REG_SEC:        rd_byte = bin_to_bcd({1'b0, now.sec}) | {src.paused, 7'd0};
            REG_MIN:        rd_byte = bin_to_bcd({1'b0, now.min});
            REG_HOUR:       rd_byte = bin_to_bcd({2'b00, now.hour});
            REG_WDAY:       rd_byte = {5'd0, wday_rd};
            REG_DATE:       rd_byte = bin_to_bcd({2'b00, now.date});
            REG_MONTH:      rd_byte = bin_to_bcd({3'b000, now.month});
            REG_YEAR:       rd_byte = bin_to_bcd(now.year);
            REG_CONTROL:    rd_byte = src.ctrl;
            REG_OSC_STATUS: rd_byte = src.status;
            default:        rd_byte = alarm[alarm_off[2:0]];
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2crtc_set_conv.sv =====
`default_nettype none

module i2crtc_set_conv
    import i2crtc_pkg::*;
(
    input  bank_t      staging,
    input  logic [7:0] year_byte,
    output set_t       set_val
);

    // BCD byte to binary: high nibble * 10 + low nibble
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        begin
            bcd_to_bin = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0}
                         + {4'd0, b[3:0]};
        end
    endfunction

    logic [7:0] sec_bin;
    logic [7:0] hour_bin;
    logic [7:0] date_bin;
    logic [7:0] month_bin;
    logic [2:0] wd;

    assign sec_bin   = bcd_to_bin(staging[REG_SEC[2:0]] & 8'h7F);
    assign hour_bin  = bcd_to_bin(staging[REG_HOUR[2:0]] & 8'h3F);
    assign date_bin  = bcd_to_bin(staging[REG_DATE[2:0]] & 8'h3F);
    assign month_bin = bcd_to_bin(staging[REG_MONTH[2:0]] & 8'h1F);
    assign wd        = staging[REG_WDAY[2:0]][2:0];

    // Field conversion with range clamps on date and month
    always_comb
    begin
        set_val.sec  = sec_bin[6:0];
        set_val.min  = bcd_to_bin(staging[REG_MIN[2:0]]);
        set_val.hour = hour_bin[5:0];
        // Sunday (1) and zero go to 7, others step down by one
        set_val.wday = (wd == 3'd0 || wd == 3'd1) ? 3'd7 : wd - 3'd1;
        if (date_bin == 8'd0 || date_bin > 8'd31)
            set_val.date = 5'd1;
        else
            set_val.date = date_bin[4:0];
        if (month_bin == 8'd0 || month_bin > 8'd12)
            set_val.month = 4'd1;
        else
            set_val.month = month_bin[3:0];
        set_val.year = bcd_to_bin(year_byte);
    end

endmodule

`default_nettype wire

// ===== rtl/core/i2crtc_regfile.sv =====
`default_nettype none

module i2crtc_regfile
    import i2crtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  mode_t      mode,
    input  logic [7:0] data_byte,
    input  now_t       now,
    output res_t       res
);

    logic [3:0] ptr_reg,     ptr_next;
    logic       expect_reg,  expect_next;
    logic       trans_reg,   trans_next;
    logic       paused_reg,  paused_next;
    logic [7:0] ctrl_reg,    ctrl_next;
    logic [7:0] status_reg,  status_next;
    bank_t      alarm_reg,   alarm_next;
    bank_t      staging_reg, staging_next;

    logic       rd_en;
    logic       wr_en;
    logic       set_en;
    logic [3:0] alarm_off;
    logic [7:0] rd_byte;
    rd_src_t    rd_src;
    set_t       set_conv;

    assign rd_src.ptr    = ptr_reg;
    assign rd_src.paused = paused_reg;
    assign rd_src.ctrl   = ctrl_reg;
    assign rd_src.status = status_reg;
    assign alarm_off     = ptr_reg - REG_ALARM_0;

    i2crtc_bcd_read u_bcd_read
    (
        .src     (rd_src),
        .alarm   (alarm_reg),
        .now     (now),
        .rd_byte (rd_byte)
    );

    i2crtc_set_conv u_set_conv
    (
        .staging   (staging_reg),
        .year_byte (data_byte),
        .set_val   (set_conv)
    );

    // Event decode and register writes
    always_comb
    begin
        ptr_next     = ptr_reg;
        expect_next  = expect_reg;
        trans_next   = trans_reg;
        paused_next  = paused_reg;
        ctrl_next    = ctrl_reg;
        status_next  = status_reg;
        alarm_next   = alarm_reg;
        staging_next = staging_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        set_en       = 1'b0;

        unique case (mode) inside
            EV_ADDR_RD:
            begin
                trans_next = 1'b1;
                rd_en      = 1'b1;
                ptr_next   = ptr_reg + 4'd1;
            end
            EV_ADDR_WR, EV_STOP:
            begin
                trans_next  = 1'b0;
                expect_next = 1'b1;
            end
            EV_RX_BYTE:
            begin
                if (expect_reg)
                begin
                    ptr_next    = data_byte[3:0];
                    expect_next = 1'b0;
                end
                else
                begin
                    wr_en    = 1'b1;
                    ptr_next = ptr_reg + 4'd1;
                end
            end
            EV_TX_REQ:
            begin
                if (trans_reg)
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + 4'd1;
                end
            end
            EV_TX_NACK:
            begin
                trans_next = 1'b0;
            end
            EV_BUS_ERR:
            begin
                ptr_next    = REG_SEC;
                expect_next = 1'b1;
                trans_next  = 1'b0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase

        // Write to the register at the pointer
        if (wr_en)
        begin
            case (ptr_reg) inside
                REG_SEC:
                begin
                    staging_next               = '0;
                    staging_next[REG_SEC[2:0]] = data_byte;
                end
                [REG_MIN:REG_MONTH]:
                begin
                    staging_next[ptr_reg[2:0]] = data_byte;
                end
                REG_YEAR:
                begin
                    staging_next[REG_YEAR[2:0]] = data_byte;
                    paused_next                 = 1'b0;
                    set_en                      = 1'b1;
                end
                REG_CONTROL:
                begin
                    ctrl_next = data_byte;
                    if (data_byte[7])
                        paused_next = 1'b1;
                end
                REG_OSC_STATUS:
                begin
                    status_next = {1'b0, data_byte[6:0]};
                end
                default:
                begin
                    alarm_next[alarm_off[2:0]] = data_byte;
                end
            endcase
        end

        // Result
        res.tx_data  = rd_en ? rd_byte : 8'd0;
        res.tx_valid = rd_en;
        res.set_time = set_en;
        res.set_val  = set_en ? set_conv : '0;
        res.paused   = paused_next;
    end

    // State registers, updated once per processed event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= REG_SEC;
            expect_reg  <= 1'b1;
            trans_reg   <= 1'b0;
            paused_reg  <= 1'b0;
            ctrl_reg    <= 8'd0;
            status_reg  <= STAT_RESET;
            alarm_reg   <= '0;
            staging_reg <= '0;
        end
        else if (fire)
        begin
            ptr_reg     <= ptr_next;
            expect_reg  <= expect_next;
            trans_reg   <= trans_next;
            paused_reg  <= paused_next;
            ctrl_reg    <= ctrl_next;
            status_reg  <= status_next;
            alarm_reg   <= alarm_next;
            staging_reg <= staging_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/i2c_rtc_register_slave_test.sv =====
`timescale 1ns / 100ps

module i2c_rtc_register_slave_test;
    import i2crtc_pkg::*;

    // Event code 7 is outside the enum; the block must leave its state alone
    localparam logic [2:0] EV_UNUSED = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_byte;
        now_t       now;
    } bus_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    i2c_rtc_register_slave dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Bus events waiting to be sent, responses waiting to arrive
    bus_event_t bus_events[$];
    res_t       expected_responses[$];
    bus_event_t driven_event;

    // Register file as the testbench sees it
    logic [3:0] rtc_ptr = REG_SEC;
    logic       want_ptr_byte = 1'b1;
    logic       tx_active = 1'b0;
    logic       osc_paused = 1'b0;
    logic [7:0] ctrl_q = 8'h00;
    logic [7:0] status_q = STAT_RESET;
    logic [7:0] alarm_bytes [0:BANK_CNT-1] = '{default: 8'h00};
    logic [7:0] staged_time [0:BANK_CNT-1] = '{default: 8'h00};

    int stimulus_count = 0;
    int events_accepted = 0;
    int responses_checked = 0;
    int tx_bytes_seen = 0;
    int set_cmds_seen = 0;
    int mismatch_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycle_count = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("i2c_rtc_register_slave_test: FAIL");
        $finish;
    end

    function automatic logic [7:0] bcd_of(input int unsigned v);
        int unsigned packed_v;
        packed_v = ((v / 10) << 4) | (v % 10);
        return packed_v[7:0];
    endfunction

    function automatic logic [7:0] binary_of(input logic [7:0] b);
        int unsigned v;
        v = b[3:0] + b[7:4] * 10;
        return v[7:0];
    endfunction

    // Live time comes back in BCD; alarms and control/status as stored
    function automatic logic [7:0] read_register(input logic [3:0] r, input now_t n);
        logic [7:0] wd;
        case (r)
            REG_SEC:        return bcd_of(n.sec) | (osc_paused ? 8'h80 : 8'h00);
            REG_MIN:        return bcd_of(n.min);
            REG_HOUR:       return bcd_of(n.hour);
            REG_WDAY:
            begin
                wd = (n.wday % 7) + 1;
                return wd;
            end
            REG_DATE:       return bcd_of(n.date);
            REG_MONTH:      return bcd_of(n.month);
            REG_YEAR:       return bcd_of(n.year);
            REG_CONTROL:    return ctrl_q;
            REG_OSC_STATUS: return status_q;
            default:        return alarm_bytes[r - REG_ALARM_0];
        endcase
    endfunction

    // Returns 1 when the write completes a set-time command
    function automatic bit write_register(input logic [3:0] r, input logic [7:0] v);
        if (r <= REG_YEAR) begin
            if (r == REG_SEC)
                staged_time = '{default: 8'h00};
            staged_time[r] = v;
            if (r == REG_YEAR) begin
                osc_paused = 1'b0;
                return 1'b1;
            end
        end
        else if (r == REG_CONTROL) begin
            ctrl_q = v;
            if (v[7])
                osc_paused = 1'b1;
        end
        else if (r == REG_OSC_STATUS) begin
            status_q = v & 8'h7F;
        end
        else begin
            alarm_bytes[r - REG_ALARM_0] = v;
        end
        return 1'b0;
    endfunction

    function automatic res_t register_file_response(input bus_event_t ev);
        res_t       res;
        bit         set_cmd;
        logic [2:0] wd;
        logic [7:0] mo;
        logic [7:0] dt;
        logic [7:0] conv;
        res = '0;
        set_cmd = 1'b0;
        case (ev.mode) inside
            EV_ADDR_RD:
            begin
                tx_active = 1'b1;
                res.tx_data = read_register(rtc_ptr, ev.now);
                res.tx_valid = 1'b1;
                rtc_ptr = rtc_ptr + 4'd1;
            end
            EV_ADDR_WR, EV_STOP:
            begin
                tx_active = 1'b0;
                want_ptr_byte = 1'b1;
            end
            EV_RX_BYTE:
            begin
                if (want_ptr_byte) begin
                    rtc_ptr = ev.data_byte[3:0];
                    want_ptr_byte = 1'b0;
                end
                else begin
                    set_cmd = write_register(rtc_ptr, ev.data_byte);
                    rtc_ptr = rtc_ptr + 4'd1;
                end
            end
            EV_TX_REQ:
            begin
                if (tx_active) begin
                    res.tx_data = read_register(rtc_ptr, ev.now);
                    res.tx_valid = 1'b1;
                    rtc_ptr = rtc_ptr + 4'd1;
                end
            end
            EV_TX_NACK:
                tx_active = 1'b0;
            EV_BUS_ERR:
            begin
                rtc_ptr = REG_SEC;
                want_ptr_byte = 1'b1;
                tx_active = 1'b0;
            end
            default: ;
        endcase

        // Staged BCD to binary; weekday renumbered from Sunday-first
        if (set_cmd) begin
            wd = staged_time[REG_WDAY][2:0];
            if (wd == 3'd0)
                wd = 3'd1;
            wd = (wd == 3'd1) ? 3'd7 : wd - 3'd1;
            mo = binary_of(staged_time[REG_MONTH] & 8'h1F);
            dt = binary_of(staged_time[REG_DATE] & 8'h3F);
            if (mo < 1 || mo > 12)
                mo = 8'd1;
            if (dt < 1 || dt > 31)
                dt = 8'd1;
            res.set_time = 1'b1;
            conv = binary_of(staged_time[REG_SEC] & 8'h7F);
            res.set_val.sec = conv[6:0];
            res.set_val.min = binary_of(staged_time[REG_MIN]);
            conv = binary_of(staged_time[REG_HOUR] & 8'h3F);
            res.set_val.hour = conv[5:0];
            res.set_val.wday = wd;
            res.set_val.date = dt[4:0];
            res.set_val.month = mo[3:0];
            res.set_val.year = binary_of(staged_time[REG_YEAR]);
        end
        res.paused = osc_paused;
        return res;
    endfunction

    // Mostly legal times, now and then any value the field widths allow
    function automatic now_t rand_now();
        now_t n;
        if ($urandom_range(0, 7) == 0) begin
            n.sec = 6'($urandom);
            n.min = 6'($urandom);
            n.hour = 5'($urandom);
            n.wday = 3'($urandom);
            n.date = 5'($urandom);
            n.month = 4'($urandom);
            n.year = 7'($urandom);
        end
        else begin
            n.sec = 6'($urandom_range(0, 59));
            n.min = 6'($urandom_range(0, 59));
            n.hour = 5'($urandom_range(0, 23));
            n.wday = 3'($urandom_range(1, 7));
            n.date = 5'($urandom_range(1, 31));
            n.month = 4'($urandom_range(1, 12));
            n.year = 7'($urandom_range(0, 99));
        end
        return n;
    endfunction

    function automatic logic [7:0] rand_bcd(input int unsigned max_v);
        return bcd_of($urandom_range(0, max_v));
    endfunction

    task automatic queue_event(input logic [2:0] mode, input logic [7:0] b, input now_t n);
        bus_event_t ev;
        ev.mode = mode;
        ev.data_byte = b;
        ev.now = n;
        bus_events.push_back(ev);
        if (mode != EV_UNUSED)
            stimulus_count++;
    endtask

    // Stimulus: directed opening, then random bus transactions
    initial begin
        now_t        now_max;
        now_t        now_wide;
        int unsigned bcd_limit [0:6];
        int          n;
        now_max = '{sec: 59, min: 59, hour: 23, wday: 7, date: 31, month: 12, year: 99};
        now_wide = '{sec: 63, min: 63, hour: 31, wday: 0, date: 0, month: 15, year: 127};
        bcd_limit = '{59, 59, 23, 7, 31, 12, 99};

        // Transmit request with no read in progress, unused code
        queue_event(EV_TX_REQ, 8'hFF, now_max);
        queue_event(EV_UNUSED, 8'hFF, now_max);
        // Read live time at its maximum, then NACK ends the read
        queue_event(EV_ADDR_RD, 8'h00, now_max);
        queue_event(EV_TX_REQ, 8'h00, now_max);
        queue_event(EV_TX_REQ, 8'h00, now_max);
        queue_event(EV_TX_REQ, 8'h00, now_max);
        queue_event(EV_TX_NACK, 8'h00, now_max);
        queue_event(EV_TX_REQ, 8'h00, now_max);
        // Pause through control bit 7, status write drops bit 7, wrap to seconds
        queue_event(EV_ADDR_WR, 8'h00, now_max);
        queue_event(EV_RX_BYTE, {4'hF, REG_CONTROL}, now_max);
        queue_event(EV_RX_BYTE, 8'h80, now_max);
        queue_event(EV_RX_BYTE, 8'hFF, now_max);
        queue_event(EV_RX_BYTE, 8'h5A, now_max);
        queue_event(EV_STOP, 8'h00, now_max);
        // Bus error resets the pointer; read out-of-range time with pause bit
        queue_event(EV_BUS_ERR, 8'h00, now_max);
        queue_event(EV_ADDR_RD, 8'h00, now_wide);
        queue_event(EV_STOP, 8'h00, now_wide);
        // Set time: seconds bit 7 masked, weekday 0, date 0 and month 13 clamped
        queue_event(EV_ADDR_WR, 8'h00, now_max);
        queue_event(EV_RX_BYTE, {4'h0, REG_SEC}, now_max);
        queue_event(EV_RX_BYTE, 8'hD9, now_max);
        queue_event(EV_RX_BYTE, 8'h59, now_max);
        queue_event(EV_RX_BYTE, 8'h23, now_max);
        queue_event(EV_RX_BYTE, 8'h00, now_max);
        queue_event(EV_RX_BYTE, 8'h00, now_max);
        queue_event(EV_RX_BYTE, 8'h13, now_max);
        queue_event(EV_RX_BYTE, 8'h99, now_max);
        queue_event(EV_STOP, 8'h00, now_max);

        while (stimulus_count < 400) begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    // full time write from seconds, mostly valid BCD
                    queue_event(EV_ADDR_WR, 8'($urandom), rand_now());
                    queue_event(EV_RX_BYTE, {4'($urandom), REG_SEC}, rand_now());
                    for (int k = 0; k < 7; k++) begin
                        if ($urandom_range(0, 4) == 0)
                            queue_event(EV_RX_BYTE, 8'($urandom), rand_now());
                        else
                            queue_event(EV_RX_BYTE, rand_bcd(bcd_limit[k]), rand_now());
                    end
                    queue_event(EV_STOP, 8'($urandom), rand_now());
                end
                3, 4, 8:
                begin
                    // register write from a random pointer
                    n = $urandom_range(1, 8);
                    queue_event(EV_ADDR_WR, 8'($urandom), rand_now());
                    queue_event(EV_RX_BYTE, 8'($urandom), rand_now());
                    for (int k = 0; k < n; k++)
                        queue_event(EV_RX_BYTE, 8'($urandom), rand_now());
                    queue_event(EV_STOP, 8'($urandom), rand_now());
                end
                5, 6, 7:
                begin
                    // register read, usually after setting the pointer
                    n = $urandom_range(0, 16);
                    if ($urandom_range(0, 2) != 0) begin
                        queue_event(EV_ADDR_WR, 8'($urandom), rand_now());
                        queue_event(EV_RX_BYTE, 8'($urandom), rand_now());
                    end
                    queue_event(EV_ADDR_RD, 8'($urandom), rand_now());
                    for (int k = 0; k < n; k++)
                        queue_event(EV_TX_REQ, 8'($urandom), rand_now());
                    queue_event(EV_TX_NACK, 8'($urandom), rand_now());
                    queue_event(EV_STOP, 8'($urandom), rand_now());
                end
                default:
                begin
                    // noise: any event code, any byte
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        queue_event(3'($urandom), 8'($urandom), rand_now());
                end
            endcase
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain: everything sent, everything answered, then a short tail
        while (bus_events.size() > 0 || s_tvalid)
            @(posedge clk);
        while (expected_responses.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d bus events; checked %0d responses, %0d transmit bytes, %0d set-time",
            events_accepted, responses_checked, tx_bytes_seen, set_cmds_seen);
        $display("commands, with random source gaps and sink stalls including one long hold-off.");
        if (mismatch_count == 0)
            $display("i2c_rtc_register_slave_test: PASS");
        else
            $display("i2c_rtc_register_slave_test: FAIL");
        $finish;
    end

    // Request driver: bursts with random gaps
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_responses.push_back(register_file_response(driven_event));
                events_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (bus_events.size() > 0) begin
                    driven_event = bus_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, driven_event.now.year, driven_event.now.month,
                        driven_event.now.date, driven_event.now.wday, driven_event.now.hour,
                        driven_event.now.min, driven_event.now.sec, driven_event.data_byte};
                    s_tuser <= driven_event.mode;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end
                    else begin
                        burst_left--;
                    end
                end
                else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // Response monitor and sink stall pattern
    always @(posedge clk) begin
        res_t exp_r;
        if (rst_n) begin
            cycle_count++;
            if (m_tvalid && m_tready) begin
                if (expected_responses.size() == 0) begin
                    $error("response with none expected: tdata 0x%0h tuser 0x%0h",
                        m_tdata, m_tuser);
                    mismatch_count++;
                end
                else begin
                    exp_r = expected_responses.pop_front();
                    check_field("tx_data", exp_r.tx_data, m_tdata[7:0]);
                    check_field("tx_valid", exp_r.tx_valid, m_tuser[0]);
                    check_field("set_time", exp_r.set_time, m_tuser[1]);
                    check_field("set_sec", exp_r.set_val.sec, m_tdata[14:8]);
                    check_field("set_min", exp_r.set_val.min, m_tdata[22:15]);
                    check_field("set_hour", exp_r.set_val.hour, m_tdata[28:23]);
                    check_field("set_wday", exp_r.set_val.wday, m_tdata[31:29]);
                    check_field("set_date", exp_r.set_val.date, m_tdata[36:32]);
                    check_field("set_month", exp_r.set_val.month, m_tdata[40:37]);
                    check_field("set_year", exp_r.set_val.year, m_tdata[48:41]);
                    check_field("oscillator_paused", exp_r.paused, m_tdata[49]);
                    responses_checked++;
                    if (exp_r.tx_valid)
                        tx_bytes_seen++;
                    if (exp_r.set_time)
                        set_cmds_seen++;
                end
            end

            // one long hold-off so the block backs up into its input
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && responses_checked >= 120) begin
                hold_done = 1'b1;
                hold_left = 64;
                m_tready <= 1'b0;
            end
            else begin
                case ((cycle_count / 48) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= cycle_count[0];
                endcase
            end
        end
    end

endmodule
